@@ sv/rfdts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdts_pkg: shared types and constants of the RFID frame deframer
// Frame layout constants, status codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package rfdts_pkg;

  localparam int MAX_FRAME_BYTES = 29;
  localparam int TAG_SLOTS       = 5;
  localparam int FRAMES_PER_SLOT = 128;

  localparam logic [7:0] START_BYTE = 8'hBB;
  localparam logic [7:0] END_BYTE   = 8'h7E;
  localparam logic [7:0] NOISE_B1   = 8'h01;
  localparam logic [7:0] NOISE_B2   = 8'hFF;
  localparam logic [7:0] NOISE_RSSI = 8'h15;
  localparam int         KEY_POS    = 22;
  localparam int         OVERHEAD   = 7;

  // byte counter holds 0 .. MAX_FRAME_BYTES-1
  localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SLOT_W = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
  // payload length plus overhead, up to 255 + 7
  localparam int TOT_W  = 9;

  typedef enum logic [2:0] {
    FS_STORED   = 3'd0,
    FS_FILTERED = 3'd1,
    FS_FULL     = 3'd2,
    FS_BAD_END  = 3'd3,
    FS_TOO_LONG = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic byte_xfer;  // an input byte transfers this cycle
    logic eval;       // resolve the finished frame into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic may_finish; // the next byte could end or drop the frame
    logic finish;     // the byte on the input ends or drops the frame
  } dp_status_t;

endpackage

@@ sv/rfdts_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdts_in_if: received byte channel
// Valid/ready channel carrying one serial byte per transfer.
// ----------------------------------------------------------------------------
interface rfdts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/rfdts_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdts_out_if: frame result channel
// Valid/ready channel carrying one frame report per transfer.
// ----------------------------------------------------------------------------
interface rfdts_out_if;
  logic              valid;
  logic              ready;
  logic        [2:0] status;
  logic        [2:0] slot_index;
  logic signed [7:0] rssi;
  logic        [4:0] frame_length;
  logic        [7:0] slot_count;

  modport source (output valid, output status, output slot_index, output rssi,
                  output frame_length, output slot_count, input ready);
  modport sink   (input valid, input status, input slot_index, input rssi,
                  input frame_length, input slot_count, output ready);
endinterface

@@ sv/rfdts_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdts_dp: deframer datapath
// Byte counter, captured header bytes, tag slot table and output register.
// ----------------------------------------------------------------------------
module rfdts_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rfdts_pkg::dp_cmd_t          cmd,
  output rfdts_pkg::dp_status_t       stat,
  input  logic                  [7:0] rx_byte,
  output logic                  [2:0] status,
  output logic                  [2:0] slot_index,
  output logic signed           [7:0] rssi,
  output logic                  [4:0] frame_length,
  output logic                  [7:0] slot_count
);

  localparam int CntW  = rfdts_pkg::CNT_W;
  localparam int SlotW = rfdts_pkg::SLOT_W;
  localparam int TotW  = rfdts_pkg::TOT_W;
  localparam int Slots = rfdts_pkg::TAG_SLOTS;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      b1_r, b2_r, b4_r, b5_r;
  logic [7:0]      key_r;
  logic            too_long_r, bad_end_r;
  logic [7:0]      slot_key_r [Slots];
  logic [7:0]      slot_cnt_r [Slots];

  logic [TotW-1:0] total;
  logic [CntW:0]   cnt_inc;
  logic            too_long;
  logic            filtered;
  logic            hit_found;
  logic [SlotW-1:0] hit_idx;
  logic [7:0]      cnt_sel;
  logic [7:0]      cnt_new;
  rfdts_pkg::frame_status_t res_status;

  assign total    = TotW'(b4_r) + TotW'(rfdts_pkg::OVERHEAD);
  assign cnt_inc  = {1'b0, cnt_r} + (CntW+1)'(1);
  assign too_long = (total > TotW'(rfdts_pkg::MAX_FRAME_BYTES));

  // from byte five on, each byte may drop the frame or end it
  assign stat.may_finish = (cnt_r >= CntW'(5)) &&
                           (too_long || (TotW'(cnt_inc) == total));
  assign stat.finish     = stat.may_finish;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.byte_xfer) begin
      if (cnt_r == '0) begin
        if (rx_byte == rfdts_pkg::START_BYTE) cnt_nxt = CntW'(1);
      end else if (stat.finish) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // capture the header bytes; keep the key byte stale across short frames
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= 8'h00;
    end else if (cmd.byte_xfer && cnt_r == CntW'(rfdts_pkg::KEY_POS)) begin
      key_r <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_xfer) begin
      if (cnt_r == CntW'(1)) b1_r <= rx_byte;
      if (cnt_r == CntW'(2)) b2_r <= rx_byte;
      if (cnt_r == CntW'(4)) b4_r <= rx_byte;
      if (cnt_r == CntW'(5)) b5_r <= rx_byte;
      if (stat.finish && cnt_r != '0) begin
        too_long_r <= too_long;
        bad_end_r  <= (rx_byte != rfdts_pkg::END_BYTE);
      end
    end
  end

  // first slot that holds the key or is empty
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (slot_key_r[i] == key_r || slot_key_r[i] == 8'h00) begin
        hit_found = 1'b1;
        hit_idx   = SlotW'(i);
      end
    end
  end

  assign cnt_sel  = slot_cnt_r[hit_idx];
  assign cnt_new  = (cnt_sel < 8'(rfdts_pkg::FRAMES_PER_SLOT)) ? cnt_sel + 8'd1 : cnt_sel;
  assign filtered = (b5_r == 8'h00) ||
                    (b1_r == rfdts_pkg::NOISE_B1 && b2_r == rfdts_pkg::NOISE_B2 &&
                     b5_r == rfdts_pkg::NOISE_RSSI);

  always_comb begin
    priority if (too_long_r) begin
      res_status = rfdts_pkg::FS_TOO_LONG;
    end else if (bad_end_r) begin
      res_status = rfdts_pkg::FS_BAD_END;
    end else if (filtered) begin
      res_status = rfdts_pkg::FS_FILTERED;
    end else if (!hit_found) begin
      res_status = rfdts_pkg::FS_FULL;
    end else begin
      res_status = rfdts_pkg::FS_STORED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Slots; i++) begin
        slot_key_r[i] <= 8'h00;
        slot_cnt_r[i] <= 8'h00;
      end
    end else if (cmd.eval && res_status == rfdts_pkg::FS_STORED) begin
      slot_key_r[hit_idx] <= key_r;
      slot_cnt_r[hit_idx] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status       <= res_status;
      rssi         <= b5_r;
      frame_length <= too_long_r ? 5'd0 : total[4:0];
      if (res_status == rfdts_pkg::FS_STORED) begin
        slot_index <= 3'(hit_idx);
        slot_count <= cnt_new;
      end else begin
        slot_index <= 3'd0;
        slot_count <= 8'd0;
      end
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CntW'(rfdts_pkg::MAX_FRAME_BYTES))
    else $error("byte counter ran past the frame limit");

  a_slot_sat: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r[0] <= 8'(rfdts_pkg::FRAMES_PER_SLOT))
    else $error("slot count passed saturation");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_xfer && stat.finish |=> cnt_r == '0)
    else $error("hunt did not restart after frame end");

endmodule

@@ sv/rfdts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfdts_ctrl: deframer controller
// Sequences byte reception, frame evaluation and the output handshake.
// ----------------------------------------------------------------------------
module rfdts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rfdts_pkg::dp_status_t stat,
  output rfdts_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_RX   = 2'b01,
    S_EVAL = 2'b10
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // in receive, stall only a byte that may report while the report slot is busy
  assign in_ready      = (state_r == S_RX) &&
                         (!stat.may_finish || !out_valid_r || out_ready);
  assign cmd.byte_xfer = in_valid && in_ready;
  assign cmd.eval      = (state_r == S_EVAL);
  assign out_valid     = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RX: begin
        if (cmd.byte_xfer && stat.finish) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_RX;
      end
      default: begin
        state_nxt = S_RX;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.eval) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_eval_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |=> state_r == S_RX)
    else $error("evaluation lasted more than one cycle");

  a_eval_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> !out_valid_r)
    else $error("evaluation would overwrite a pending report");

  a_no_rx_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> !in_ready)
    else $error("byte taken during evaluation");

endmodule

@@ sv/rfid_frame_deframer_tag_sorter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_frame_deframer_tag_sorter: RFID reader frame deframer and tag sorter
// A frame's last byte starts evaluation, which fills the output register.
// Throughput: one byte per cycle, none in evaluation (slot lookup and update);
//   a frame's final byte waits while the previous report is unsent.
// Reset: synchronous, active low; clears the hunt, the slot table and the
//   stale key byte, and clears the output valid flag.
// ----------------------------------------------------------------------------
module rfid_frame_deframer_tag_sorter (
  input  logic        clk,
  input  logic        rst_n,
  rfdts_in_if.sink    in_ch,
  rfdts_out_if.source out_ch
);

  rfdts_pkg::dp_cmd_t    cmd;
  rfdts_pkg::dp_status_t stat;

  // Controller: two states. In receive it takes a byte every cycle, but holds
  // off a byte that could close a frame while the previous report still waits
  // for its transfer. The evaluation state then resolves the frame.
  rfdts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: byte counter and header capture (bytes 1, 2, 4, 5 and the key
  // byte 22), the end-byte and length checks, the parallel slot search and
  // the output register that holds the report until it transfers.
  rfdts_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .rx_byte      (in_ch.rx_byte),
    .status       (out_ch.status),
    .slot_index   (out_ch.slot_index),
    .rssi         (out_ch.rssi),
    .frame_length (out_ch.frame_length),
    .slot_count   (out_ch.slot_count)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RFID frame deframer and tag sorter
// Streams received bytes through the valid/ready input channel, predicts
// every frame report with its own deframer and slot table, and compares
// each report on the result channel field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  // One frame report, laid out as the result channel carries it.
  typedef struct packed {
    rfdts_pkg::frame_status_t status;
    logic        [2:0]        slot;
    logic signed [7:0]        rssi;
    logic        [4:0]        flen;
    logic        [7:0]        count;
  } frame_report_t;

  // One row of the directed byte stream. Where 'typed' is set, the report
  // that this byte completes is written out by hand instead of predicted.
  typedef struct packed {
    logic [7:0]    b;
    bit            typed;
    frame_report_t rpt;
  } seed_row_t;

  localparam frame_report_t NO_RPT = '0;
  localparam int ITEM_BUDGET = 1450;
  localparam int HAMMER_FRAMES = 135;

  logic clk;
  logic rst_n;

  rfdts_in_if  in_ch ();
  rfdts_out_if out_ch ();

  rfid_frame_deframer_tag_sorter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Period 10 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the bytes held of the current frame, the frame buffer
  // with its stale tail, and the tag slot table.
  // --------------------------------------------------------------------------
  int unsigned held;
  logic [7:0]  fbuf      [0:rfdts_pkg::MAX_FRAME_BYTES];
  logic [7:0]  tag_key   [rfdts_pkg::TAG_SLOTS];
  logic [7:0]  tag_frames[rfdts_pkg::TAG_SLOTS];

  frame_report_t due_reports[$];   // reports predicted but not yet seen
  int            mismatches;
  int            sent_bytes;       // every byte transferred into the block
  bit            gaps_on;          // random idling on both channels
  logic [7:0]    frame_bytes[$];   // frame being assembled for transfer

  // Advance the deframer by one byte. Returns 1 when the byte completes or
  // drops a frame, with the report that this causes.
  function automatic bit deframe_byte(input logic [7:0] b, output frame_report_t rpt);
    int         total;
    int         hit;
    logic [7:0] rs;
    logic [7:0] key;
    rpt = NO_RPT;
    if (held == 0) begin
      // hunting: anything but the start byte is dropped silently
      if (b != rfdts_pkg::START_BYTE) return 1'b0;
      fbuf[0] = b;
      held = 1;
    end else if (held < rfdts_pkg::MAX_FRAME_BYTES) begin
      fbuf[held] = b;
      held++;
    end else begin
      held = 0;
      return 1'b0;
    end
    if (held <= 5) return 1'b0;

    total = fbuf[4] + rfdts_pkg::OVERHEAD;
    rs = fbuf[5];
    rpt.rssi = rs;
    if (total > rfdts_pkg::MAX_FRAME_BYTES) begin
      rpt.status = rfdts_pkg::FS_TOO_LONG;
      held = 0;
      return 1'b1;
    end
    if (held < total) return 1'b0;

    held = 0;
    rpt.flen = total[4:0];
    if (fbuf[total - 1] != rfdts_pkg::END_BYTE) begin
      rpt.status = rfdts_pkg::FS_BAD_END;
      return 1'b1;
    end
    if (rs == 8'h00 || (fbuf[1] == rfdts_pkg::NOISE_B1 && fbuf[2] == rfdts_pkg::NOISE_B2 &&
                        rs == rfdts_pkg::NOISE_RSSI)) begin
      rpt.status = rfdts_pkg::FS_FILTERED;
      return 1'b1;
    end

    // First slot holding this key or empty; a short frame keys on the
    // stale byte left in the buffer.
    key = fbuf[rfdts_pkg::KEY_POS];
    hit = -1;
    for (int s = 0; s < rfdts_pkg::TAG_SLOTS; s++) begin
      if (hit < 0 && (tag_key[s] == key || tag_key[s] == 8'h00)) hit = s;
    end
    if (hit < 0) begin
      rpt.status = rfdts_pkg::FS_FULL;
      return 1'b1;
    end
    tag_key[hit] = key;
    if (tag_frames[hit] < rfdts_pkg::FRAMES_PER_SLOT) tag_frames[hit]++;
    rpt.status = rfdts_pkg::FS_STORED;
    rpt.slot   = hit[2:0];
    rpt.count  = tag_frames[hit];
    return 1'b1;
  endfunction

  // Assemble a frame with payload length len and random filler. A length
  // that is too long is cut off after byte 5, where the deframer drops it.
  function automatic void build_frame(input int len, input logic [7:0] key,
                                      input logic [7:0] rssi, input logic [7:0] end_b,
                                      input bit noise);
    int n;
    n = (len + rfdts_pkg::OVERHEAD > rfdts_pkg::MAX_FRAME_BYTES) ? 6
                                                                  : len + rfdts_pkg::OVERHEAD;
    frame_bytes.delete();
    frame_bytes.push_back(rfdts_pkg::START_BYTE);
    for (int i = 1; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (noise) begin
      frame_bytes[1] = rfdts_pkg::NOISE_B1;
      frame_bytes[2] = rfdts_pkg::NOISE_B2;
    end
    frame_bytes[4] = 8'(len);
    frame_bytes[5] = rssi;
    if (n > rfdts_pkg::KEY_POS) frame_bytes[rfdts_pkg::KEY_POS] = key;
    if (n == len + rfdts_pkg::OVERHEAD) frame_bytes[n - 1] = end_b;
  endfunction

  // Transfer one byte. Entered and left at a falling edge; idles first at
  // random, then holds valid until the transfer and predicts its effect.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input frame_report_t typed_rpt = '0);
    frame_report_t rpt;
    bit            fired;
    while (gaps_on && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
    fired = deframe_byte(b, rpt);
    if (fired) due_reports.push_back(typed ? typed_rpt : rpt);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed stream: hunting noise, a length that is too long, a noise
  // frame, a bad end byte and a zero RSSI, with the extremes of RSSI.
  // --------------------------------------------------------------------------
  seed_row_t seed_rows [28] = '{
    '{8'hFF, 1'b0, NO_RPT},
    // payload length 255
    '{8'hBB, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT},
    '{8'h00, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT},
    '{8'h80, 1'b1, '{rfdts_pkg::FS_TOO_LONG, 3'd0, 8'h80, 5'd0, 8'd0}},
    // reader noise pattern 01 FF .. 15
    '{8'hBB, 1'b0, NO_RPT}, '{8'h01, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT},
    '{8'h00, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT}, '{8'h15, 1'b0, NO_RPT},
    '{8'h7E, 1'b1, '{rfdts_pkg::FS_FILTERED, 3'd0, 8'h15, 5'd7, 8'd0}},
    // wrong end byte
    '{8'hBB, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT},
    '{8'h00, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT}, '{8'h7F, 1'b0, NO_RPT},
    '{8'h00, 1'b1, '{rfdts_pkg::FS_BAD_END, 3'd0, 8'h7F, 5'd7, 8'd0}},
    // zero RSSI
    '{8'hBB, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT},
    '{8'h00, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT},
    '{8'h7E, 1'b1, '{rfdts_pkg::FS_FILTERED, 3'd0, 8'h00, 5'd7, 8'd0}}
  };

  // Result side: stall at random at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 37);
  end

  // Check every report transfer against the oldest prediction.
  always @(posedge clk) begin : check_report
    frame_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected report status=%0d slot=%0d rssi=%0d len=%0d count=%0d",
                   $realtime, out_ch.status, out_ch.slot_index, out_ch.rssi,
                   out_ch.frame_length, out_ch.slot_count);
      end else begin
        want = due_reports.pop_front();
        if (out_ch.status !== want.status || out_ch.slot_index !== want.slot ||
            out_ch.rssi !== want.rssi || out_ch.frame_length !== want.flen ||
            out_ch.slot_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     $realtime, want.status, want.slot, want.rssi, want.flen, want.count,
                     out_ch.status, out_ch.slot_index, out_ch.rssi, out_ch.frame_length,
                     out_ch.slot_count);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] key_pool[8];
    logic [7:0] hammer_key;
    logic [7:0] rssi;
    logic [7:0] key;
    int         roll;
    int         len;
    int         frame_no;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    gaps_on       = 1'b1;
    held          = 0;
    mismatches    = 0;
    sent_bytes    = 0;
    for (int i = 0; i <= rfdts_pkg::MAX_FRAME_BYTES; i++) fbuf[i] = 8'h00;
    for (int s = 0; s < rfdts_pkg::TAG_SLOTS; s++) begin
      tag_key[s]    = 8'h00;
      tag_frames[s] = 8'h00;
    end
    for (int k = 0; k < 8; k++) key_pool[k] = 8'($urandom_range(1, 255));

    // Hold reset, then release it at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table.
    for (int i = 0; i < $size(seed_rows); i++)
      send_byte(seed_rows[i].b, seed_rows[i].typed, seed_rows[i].rpt);

    // Hold the sender until every report so far has come back.
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (due_reports.size() != 0);

    // Hammer one slot into saturation: a full-length frame plants the key,
    // then minimal frames reuse it as the stale key byte.
    hammer_key = 8'($urandom_range(1, 255));
    build_frame(rfdts_pkg::MAX_FRAME_BYTES - rfdts_pkg::OVERHEAD, hammer_key,
                8'($urandom_range(1, 255)), rfdts_pkg::END_BYTE, 1'b0);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    for (int f = 0; f < HAMMER_FRAMES; f++) begin
      build_frame(0, 8'h00, 8'($urandom_range(1, 255)), rfdts_pkg::END_BYTE, 1'b0);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (due_reports.size() != 0);

    // Mixed traffic: mostly well-formed frames with random content, the
    // rest too long, cut short or pure noise.
    frame_no = 0;
    while (sent_bytes < ITEM_BUDGET) begin
      // one long stretch with no idling on either side
      gaps_on = !(frame_no >= 4 && frame_no < 18);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        build_frame($urandom_range(rfdts_pkg::MAX_FRAME_BYTES - rfdts_pkg::OVERHEAD + 1, 255),
                    8'h00, 8'($urandom_range(0, 255)), rfdts_pkg::END_BYTE, 1'b0);
      end else if (roll < 14) begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        len  = ($urandom_range(0, 2) == 0)
               ? $urandom_range(17, rfdts_pkg::MAX_FRAME_BYTES - rfdts_pkg::OVERHEAD)
               : $urandom_range(0, 16);
        roll = $urandom_range(0, 99);
        rssi = (roll < 8) ? 8'h00 : (roll < 13) ? rfdts_pkg::NOISE_RSSI
                                                : 8'($urandom_range(1, 255));
        key  = ($urandom_range(0, 99) < 3) ? 8'h00 : key_pool[$urandom_range(0, 7)];
        build_frame(len, key, rssi,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : rfdts_pkg::END_BYTE,
                    roll >= 8 && roll < 13);
      end
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
      // hunting noise between frames, never a start byte
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom_range(0, rfdts_pkg::START_BYTE - 1)));
      end
      frame_no++;
    end

    // Drain: wait out every prediction, then keep watching for strays.
    in_ch.valid <= 1'b0;
    gaps_on = 1'b1;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
